@@ hw/rtl/lcrs_pkg.sv @@
// lcrs_pkg: shared types and codes for the radius top-k keyframe search
// no dependencies
`default_nettype none
package lcrs_pkg;
    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CAND   = 3'd0,
        ST_NONE   = 3'd1,
        ST_STORED = 3'd2,
        ST_REJECT = 3'd3,
        ST_ABSENT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_MIN_SEP    = 2'd0,
        CFG_MIN_TRAVEL = 2'd1,
        CFG_RADIUS     = 2'd2,
        CFG_MAX_KEPT   = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_APPEND,
        BK_QREAD,
        BK_QWAIT,
        BK_SCAN,
        BK_DRAIN,
        BK_ROOT_LOAD,
        BK_ROOT_WAIT,
        BK_ROOT,
        BK_EMIT,
        BK_SINGLE
    } back_state_t;

    // command as it travels from the front to the back through the queue
    typedef struct packed {
        action_t     action;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] travel;
        logic [9:0]  query_index;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;
endpackage
`default_nettype wire

@@ hw/rtl/lcrs_ram.sv @@
// lcrs_ram: generic single-write, single-read memory with registered read
// no dependencies
`default_nettype none
module lcrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/lcrs_queue.sv @@
// lcrs_queue: short command queue between front and back
// depends on lcrs_pkg
`default_nettype none
module lcrs_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lcrs_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output lcrs_pkg::cmd_t      head_cmd,
    output lcrs_pkg::hs_t       hs
);
    lcrs_pkg::cmd_t slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       rd_reg, wr_reg;

    assign hs.valid = (count_reg != 2'd0);
    assign hs.ready = (count_reg != 2'd2);
    assign head_cmd = slot_reg[rd_reg];

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/lcrs_back.sv @@
// lcrs_back: keyframe store, radius scan with sorted top-k list, root and emit
// depends on lcrs_pkg, lcrs_ram
`default_nettype none
module lcrs_back #(
    parameter int MAX_FRAMES     = 1024,
    parameter int MAX_CANDIDATES = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lcrs_pkg::hs_t  q_hs,
    input  wire lcrs_pkg::cmd_t cmd,
    output logic                pop,
    input  wire logic [9:0]     min_separation,
    input  wire logic [31:0]    min_travel,
    input  wire logic [30:0]    radius,
    input  wire logic [3:0]     max_kept,
    output logic                done,
    output logic [2:0]          status,
    output logic [9:0]          frame_index,
    output logic [31:0]         range,
    output logic                last
);
    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int KW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int KN = $clog2(MAX_CANDIDATES + 1);

    lcrs_pkg::back_state_t state_reg, state_next;

    logic [CW-1:0] count_reg;
    logic [31:0]   last_travel_reg;
    lcrs_pkg::cmd_t cur_reg;

    // memory ports
    logic          we;
    logic [AW-1:0] raddr;
    logic [31:0]   rx, ry, rt;

    // scan state
    logic [AW-1:0] scan_reg;
    logic [AW:0]   latest_reg;
    logic          rvalid_reg;
    logic [AW-1:0] ridx_reg;
    logic signed [31:0] qx_reg, qy_reg;
    logic [31:0]   qt_reg;
    logic [KN-1:0] limit_reg;

    // stage 1: differences
    logic          s1_valid_reg;
    logic [AW-1:0] s1_idx_reg;
    logic [32:0]   dx_reg, dy_reg;
    logic          s1_ok_reg;
    // stage 2: squares
    logic          s2_valid_reg;
    logic [AW-1:0] s2_idx_reg;
    logic [63:0]   sqx_reg, sqy_reg;
    logic          s2_ok_reg;
    // stage 3: sum
    logic          s3_valid_reg;
    logic [AW-1:0] s3_idx_reg;
    logic [63:0]   sq_reg;
    logic          s3_ok_reg;
    logic [61:0]   r2_reg;

    logic [AW-1:0] best_idx_reg [MAX_CANDIDATES];
    logic [63:0]   best_sq_reg  [MAX_CANDIDATES];
    logic [KN-1:0] best_count_reg;

    // root unit
    logic [63:0]   rem_reg;
    logic [31:0]   root_reg;
    logic [5:0]    rstep_reg;
    logic [KN-1:0] emit_reg;

    logic [2:0]    st_reg;
    logic [AW-1:0] fi_reg;
    logic [31:0]   rng_reg;
    logic          last_reg;
    logic          done_reg;

    lcrs_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES)) u_x (
        .clk(clk), .we(we), .waddr(count_reg[AW-1:0]), .wdata(cur_reg.pos_x),
        .raddr(raddr), .rdata(rx));
    lcrs_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES)) u_y (
        .clk(clk), .we(we), .waddr(count_reg[AW-1:0]), .wdata(cur_reg.pos_y),
        .raddr(raddr), .rdata(ry));
    lcrs_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES)) u_t (
        .clk(clk), .we(we), .waddr(count_reg[AW-1:0]), .wdata(cur_reg.travel),
        .raddr(raddr), .rdata(rt));

    logic append_ok;
    assign append_ok = (count_reg < CW'(MAX_FRAMES)) &&
                       ((count_reg == '0) || (cur_reg.travel >= last_travel_reg));
    assign we = (state_reg == lcrs_pkg::BK_APPEND) && append_ok;

    logic [9:0] sep;
    assign sep = (min_separation == 10'd0) ? 10'd1 : min_separation;
    logic [AW:0] qext;
    assign qext = (AW+1)'(cur_reg.query_index);
    logic query_absent;
    assign query_absent = ({1'b0, qext} >= (AW+2)'(count_reg)) ||
                          (cur_reg.query_index > 10'(MAX_FRAMES - 1));

    assign raddr = (state_reg == lcrs_pkg::BK_QREAD) ? AW'(cur_reg.query_index)
                                                     : scan_reg;
    logic pipe_busy;
    assign pipe_busy = rvalid_reg | s1_valid_reg | s2_valid_reg | s3_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcrs_pkg::BK_IDLE:
            begin
                if (q_hs.valid)
                begin
                    case (cmd.action)
                        lcrs_pkg::ACT_APPEND: state_next = lcrs_pkg::BK_APPEND;
                        lcrs_pkg::ACT_QUERY:  state_next = lcrs_pkg::BK_QREAD;
                        default:              state_next = lcrs_pkg::BK_IDLE;
                    endcase
                end
            end
            lcrs_pkg::BK_APPEND: state_next = lcrs_pkg::BK_IDLE;
            lcrs_pkg::BK_QREAD:
            begin
                if (query_absent)
                begin
                    state_next = lcrs_pkg::BK_SINGLE;
                end
                else
                begin
                    state_next = lcrs_pkg::BK_QWAIT;
                end
            end
            lcrs_pkg::BK_QWAIT:
            begin
                if ({1'b0, qext} < 12'(sep) + 12'd0)
                begin
                    state_next = lcrs_pkg::BK_SINGLE;
                end
                else
                begin
                    state_next = lcrs_pkg::BK_SCAN;
                end
            end
            lcrs_pkg::BK_SCAN:
            begin
                if ((AW+1)'(scan_reg) == latest_reg)
                begin
                    state_next = lcrs_pkg::BK_DRAIN;
                end
            end
            lcrs_pkg::BK_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = (best_count_reg == '0) ? lcrs_pkg::BK_SINGLE
                                                        : lcrs_pkg::BK_ROOT_LOAD;
                end
            end
            lcrs_pkg::BK_ROOT_LOAD: state_next = lcrs_pkg::BK_ROOT;
            lcrs_pkg::BK_ROOT:
            begin
                if (rstep_reg == 6'd31)
                begin
                    state_next = lcrs_pkg::BK_EMIT;
                end
            end
            lcrs_pkg::BK_EMIT:
            begin
                state_next = (emit_reg + KN'(1) == best_count_reg) ? lcrs_pkg::BK_IDLE
                                                                   : lcrs_pkg::BK_ROOT_LOAD;
            end
            lcrs_pkg::BK_SINGLE: state_next = lcrs_pkg::BK_IDLE;
            default: state_next = lcrs_pkg::BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop = (state_reg == lcrs_pkg::BK_IDLE) && q_hs.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcrs_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // table bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (pop && cmd.action == lcrs_pkg::ACT_CLEAR)
        begin
            count_reg <= '0;
        end
        else if (we)
        begin
            count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= cmd;
        end
        if (we)
        begin
            last_travel_reg <= cur_reg.travel;
        end
    end

    // read-valid, stage valids and candidate count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            best_count_reg <= '0;
        end
        else
        begin
            rvalid_reg   <= (state_reg == lcrs_pkg::BK_SCAN);
            s1_valid_reg <= rvalid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (state_reg == lcrs_pkg::BK_QWAIT)
            begin
                best_count_reg <= '0;
            end
            else if (s3_valid_reg && s3_ok_reg && (sq_reg <= {2'b0, r2_reg}))
            begin
                if (best_count_reg < limit_reg)
                begin
                    best_count_reg <= best_count_reg + KN'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= scan_reg;
        if (state_reg == lcrs_pkg::BK_QWAIT)
        begin
            qx_reg <= rx;
            qy_reg <= ry;
            qt_reg <= rt;
            scan_reg <= '0;
            latest_reg <= qext - (AW+1)'(sep);
            r2_reg <= 62'(radius) * 62'(radius);
            if (max_kept == 4'd0)
            begin
                limit_reg <= KN'(1);
            end
            else if (32'(max_kept) > 32'(MAX_CANDIDATES))
            begin
                limit_reg <= KN'(MAX_CANDIDATES);
            end
            else
            begin
                limit_reg <= KN'(max_kept);
            end
        end
        else if (state_reg == lcrs_pkg::BK_SCAN)
        begin
            scan_reg <= scan_reg + AW'(1);
        end
    end

    // distance pipeline
    logic signed [32:0] ddx, ddy;
    always_comb
    begin
        ddx = 33'(signed'(rx)) - 33'(qx_reg);
        ddy = 33'(signed'(ry)) - 33'(qy_reg);
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= ridx_reg;
        dx_reg <= ddx[32] ? 33'(-ddx) : 33'(ddx);
        dy_reg <= ddy[32] ? 33'(-ddy) : 33'(ddy);
        s1_ok_reg <= (qt_reg >= rt) && ((qt_reg - rt) >= min_travel);
        s2_idx_reg <= s1_idx_reg;
        s2_ok_reg <= s1_ok_reg && (dx_reg <= 33'(radius)) && (dy_reg <= 33'(radius));
        sqx_reg <= 64'(dx_reg[31:0]) * 64'(dx_reg[31:0]);
        sqy_reg <= 64'(dy_reg[31:0]) * 64'(dy_reg[31:0]);
        s3_idx_reg <= s2_idx_reg;
        s3_ok_reg <= s2_ok_reg;
        sq_reg <= sqx_reg + sqy_reg;
    end

    // sorted insert: entries strictly greater shift down one place
    logic ins;
    assign ins = s3_valid_reg && s3_ok_reg && (sq_reg <= {2'b0, r2_reg});
    always_ff @(posedge clk)
    begin
        if (ins)
        begin
            for (int i = MAX_CANDIDATES - 1; i >= 0; i--)
            begin
                if (KN'(i) < limit_reg)
                begin
                    if ((KN'(i) < best_count_reg) && (best_sq_reg[i] > sq_reg))
                    begin
                        if (i + 1 < MAX_CANDIDATES)
                        begin
                            best_idx_reg[(i + 1) % MAX_CANDIDATES] <= best_idx_reg[i];
                            best_sq_reg[(i + 1) % MAX_CANDIDATES]  <= best_sq_reg[i];
                        end
                    end
                    if (((KN'(i) >= best_count_reg) || (best_sq_reg[i] > sq_reg)) &&
                        ((i == 0) || ((KN'(i) <= best_count_reg) &&
                         (best_sq_reg[(i + MAX_CANDIDATES - 1) % MAX_CANDIDATES] <= sq_reg))))
                    begin
                        best_idx_reg[i] <= s3_idx_reg;
                        best_sq_reg[i]  <= sq_reg;
                    end
                end
            end
        end
    end

    // bit-pair restoring square root, one step a cycle
    logic [65:0] acc_reg;
    logic [65:0] acc_sh;
    logic [65:0] tr;
    always_comb
    begin
        acc_sh = {acc_reg[63:0], rem_reg[63:62]};
        tr = {32'b0, root_reg, 2'b01};
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lcrs_pkg::BK_ROOT_LOAD)
        begin
            rem_reg  <= best_sq_reg[emit_reg[KW-1:0]];
            root_reg <= '0;
            acc_reg  <= '0;
            rstep_reg <= '0;
        end
        else if (state_reg == lcrs_pkg::BK_ROOT)
        begin
            rem_reg <= {rem_reg[61:0], 2'b00};
            rstep_reg <= rstep_reg + 6'd1;
            if (acc_sh >= tr)
            begin
                acc_reg  <= acc_sh - tr;
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                acc_reg  <= acc_sh;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (state_reg == lcrs_pkg::BK_QWAIT)
            begin
                emit_reg <= '0;
            end
            if (state_reg == lcrs_pkg::BK_EMIT)
            begin
                emit_reg <= emit_reg + KN'(1);
            end
            if ((state_reg == lcrs_pkg::BK_EMIT) || (state_reg == lcrs_pkg::BK_SINGLE) ||
                (state_reg == lcrs_pkg::BK_APPEND))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            lcrs_pkg::BK_APPEND:
            begin
                st_reg <= append_ok ? lcrs_pkg::ST_STORED : lcrs_pkg::ST_REJECT;
                fi_reg <= append_ok ? count_reg[AW-1:0] : '0;
                rng_reg <= '0;
                last_reg <= 1'b1;
            end
            lcrs_pkg::BK_SINGLE:
            begin
                st_reg <= query_absent ? lcrs_pkg::ST_ABSENT : lcrs_pkg::ST_NONE;
                fi_reg <= '0;
                rng_reg <= '0;
                last_reg <= 1'b1;
            end
            lcrs_pkg::BK_EMIT:
            begin
                st_reg <= lcrs_pkg::ST_CAND;
                fi_reg <= best_idx_reg[emit_reg[KW-1:0]];
                rng_reg <= root_reg;
                last_reg <= (emit_reg + KN'(1) == best_count_reg);
            end
            default:
            begin
                st_reg <= st_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign status = st_reg;
    assign frame_index = 10'(fi_reg);
    assign range = rng_reg;
    assign last = last_reg;

    logic unused_ok;
    assign unused_ok = ^{q_hs.ready};
endmodule
`default_nettype wire

@@ hw/rtl/lcrs_front.sv @@
// lcrs_front: command intake and configuration registers
// depends on lcrs_pkg
`default_nettype none
module lcrs_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [1:0]     action,
    input  wire logic [31:0]    pos_x,
    input  wire logic [31:0]    pos_y,
    input  wire logic [31:0]    travel,
    input  wire logic [9:0]     query_index,
    input  wire lcrs_pkg::hs_t  q_hs,
    output logic                busy,
    output logic                push,
    output lcrs_pkg::cmd_t      push_cmd,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [31:0]    cfg_data,
    output logic [9:0]          min_separation,
    output logic [31:0]         min_travel,
    output logic [30:0]         radius,
    output logic [3:0]          max_kept
);
    logic [9:0]  sep_reg;
    logic [31:0] trav_reg;
    logic [30:0] rad_reg;
    logic [3:0]  kept_reg;

    // unused action code never enters the queue
    assign busy = !q_hs.ready;
    assign push = start && !busy && (action != lcrs_pkg::ACT_NONE);
    assign push_cmd = '{action: lcrs_pkg::action_t'(action), pos_x: pos_x, pos_y: pos_y,
                        travel: travel, query_index: query_index};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg  <= 10'd10;
            trav_reg <= 32'd327680;
            rad_reg  <= 31'd131072;
            kept_reg <= 4'd5;
        end
        else if (cfg_we)
        begin
            case (lcrs_pkg::cfg_index_t'(cfg_index))
                lcrs_pkg::CFG_MIN_SEP:    sep_reg  <= cfg_data[9:0];
                lcrs_pkg::CFG_MIN_TRAVEL: trav_reg <= cfg_data;
                lcrs_pkg::CFG_RADIUS:     rad_reg  <= cfg_data[30:0];
                lcrs_pkg::CFG_MAX_KEPT:   kept_reg <= cfg_data[3:0];
                default:                  sep_reg  <= sep_reg;
            endcase
        end
    end

    assign min_separation = sep_reg;
    assign min_travel = trav_reg;
    assign radius = rad_reg;
    assign max_kept = kept_reg;
endmodule
`default_nettype wire

@@ hw/rtl/loop_closure_radius_topk_search.sv @@
// loop_closure_radius_topk_search: top level of the keyframe radius top-k search
// depends on lcrs_pkg, lcrs_front, lcrs_queue, lcrs_back, lcrs_ram
//
//  channel   | signals                                            | accept
//  ----------+----------------------------------------------------+------------------
//  command   | start, busy, action, pos_x, pos_y, travel, q_index | start && !busy
//  result    | done, status, frame_index, range, last             | done (no stall)
//  config    | cfg_we, cfg_index, cfg_data                        | cfg_we
//
// a query scans table entries 0 through (query_index - min_separation), one entry a
// cycle through the store memory read port, then drains the distance pipeline, then
// passes each candidate through the shared bit-serial root unit
// reset clears the frame count and loads the config defaults; stores need no clearing pass
// a two-item queue between intake and back end keeps busy low while work runs, until it is full
`default_nettype none
module loop_closure_radius_topk_search #(
    parameter int MAX_FRAMES     = 1024,
    parameter int MAX_CANDIDATES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] pos_x,
    input  wire logic [31:0] pos_y,
    input  wire logic [31:0] travel,
    input  wire logic [9:0]  query_index,
    output logic             done,
    output logic [2:0]       status,
    output logic [9:0]       frame_index,
    output logic [31:0]      range,
    output logic             last,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    lcrs_pkg::hs_t  q_hs;
    lcrs_pkg::cmd_t push_cmd, head_cmd;
    logic           push, pop;
    logic [9:0]     min_separation;
    logic [31:0]    min_travel;
    logic [30:0]    radius;
    logic [3:0]     max_kept;

    // intake and config
    lcrs_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .action(action), .pos_x(pos_x),
        .pos_y(pos_y), .travel(travel), .query_index(query_index), .q_hs(q_hs),
        .busy(busy), .push(push), .push_cmd(push_cmd), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .min_separation(min_separation),
        .min_travel(min_travel), .radius(radius), .max_kept(max_kept));

    // decoupling queue
    lcrs_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(push_cmd), .pop(pop),
        .head_cmd(head_cmd), .hs(q_hs));

    // store, scan and emit
    lcrs_back #(.MAX_FRAMES(MAX_FRAMES), .MAX_CANDIDATES(MAX_CANDIDATES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_hs(q_hs), .cmd(head_cmd), .pop(pop),
        .min_separation(min_separation), .min_travel(min_travel), .radius(radius),
        .max_kept(max_kept), .done(done), .status(status), .frame_index(frame_index),
        .range(range), .last(last));
endmodule
`default_nettype wire

@@ hw/rtl/lcrs_checker.sv @@
// lcrs_checker: port-level assertions for the search block, bound to the top
// depends on lcrs_pkg
`default_nettype none
module lcrs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        done,
    input wire logic [2:0]  status,
    input wire logic [9:0]  frame_index,
    input wire logic [31:0] range,
    input wire logic        last
);
    // non-candidate results always close their item
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != lcrs_pkg::ST_CAND) |-> last)
        else $error("non-candidate result without last");

    a_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != lcrs_pkg::ST_CAND) |-> (range == 32'd0))
        else $error("range nonzero on non-candidate");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= lcrs_pkg::ST_ABSENT))
        else $error("bad status code");

    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == lcrs_pkg::ST_NONE || status == lcrs_pkg::ST_REJECT ||
                  status == lcrs_pkg::ST_ABSENT)) |-> (frame_index == 10'd0))
        else $error("frame index nonzero");
endmodule

bind loop_closure_radius_topk_search lcrs_checker u_checker (
    .clk(clk), .rst_n(rst_n), .done(done), .status(status),
    .frame_index(frame_index), .range(range), .last(last));
`default_nettype wire
